// ----- sv/mme_pkg.sv -----
package mme_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_ORDER_DEF  = 4;
  localparam int WORD_WIDTH_DEF = 32;

  // Order register
  localparam int            ORDER_W     = 3;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd4;

  // Item commands
  typedef enum logic [1:0] {
    CMD_WRITE_A = 2'd0,
    CMD_WRITE_B = 2'd1,
    CMD_START   = 2'd2,
    CMD_READ_C  = 2'd3
  } cmd_t;

  // Control that travels with each multiply-accumulate step
  typedef struct packed {
    logic valid;  // step carries a product
    logic first;  // first term of a dot product
    logic last;   // last term of a dot product
    logic fin;    // last term of the whole matrix
  } mac_ctrl_t;

endpackage

// ----- sv/matrix_multiply_engine_core.sv -----
// Square integer matrix multiplier. Items write elements of A or B, start
// C = A x B, or read an element of C; every item returns one result holding
// read_data (C element for reads, else zero) and the done flag. A start runs
// N*N*N multiply-accumulates through one shared multiplier and accumulator,
// one per cycle, followed by a pipeline drain through the operand RAM read,
// multiply and accumulate stages; no new item is taken meanwhile. The order
// register saturates at MAX_ORDER; indexes at or beyond N*N are ignored by
// writes and read back as zero. C reads as zero until computed.
module matrix_multiply_engine_core #(
  parameter int MAX_ORDER  = mme_pkg::MAX_ORDER_DEF,
  parameter int WORD_WIDTH = mme_pkg::WORD_WIDTH_DEF,
  parameter int IDX_W      = $clog2(MAX_ORDER * MAX_ORDER)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic [mme_pkg::ORDER_W-1:0] cfg_write_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  command,
  input  logic [IDX_W-1:0]            element_index,
  input  logic [WORD_WIDTH-1:0]       element_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [WORD_WIDTH-1:0]       read_data,
  output logic                        done_res
);
  import mme_pkg::*;

  localparam int DEPTH  = MAX_ORDER * MAX_ORDER;
  localparam int ORD_W  = $clog2(MAX_ORDER + 1);
  localparam int CNT_W  = $clog2(MAX_ORDER);
  localparam int NN_W   = 2 * ORD_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MAC   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t               state;
  logic [ORDER_W-1:0]   order_cfg;
  logic                 done_flag;

  logic [ORD_W-1:0]     order_n;
  logic [NN_W-1:0]      order_nn;
  logic                 in_range;
  logic                 in_accept;
  cmd_t                 cmd;

  // Sequencer counters and running addresses
  logic [CNT_W-1:0]     i_cnt;
  logic [CNT_W-1:0]     j_cnt;
  logic [CNT_W-1:0]     k_cnt;
  logic [IDX_W-1:0]     row_base;
  logic [IDX_W-1:0]     a_addr;
  logic [IDX_W-1:0]     b_addr;
  logic                 i_last;
  logic                 j_last;
  logic                 k_last;

  mac_ctrl_t            ctrl0;
  mac_ctrl_t            ctrl1;
  logic [IDX_W-1:0]     caddr0;
  logic [IDX_W-1:0]     caddr1;
  logic [WORD_WIDTH-1:0] a_rdata;
  logic [WORD_WIDTH-1:0] b_rdata;

  mac_ctrl_t            res_ctrl;
  logic [IDX_W-1:0]     res_addr;
  logic [WORD_WIDTH-1:0] res_data;

  logic [WORD_WIDTH-1:0] c_mem [DEPTH];
  logic [DEPTH-1:0]      c_valid;

  // Effective order and range check
  always_comb begin
    if (int'(order_cfg) > MAX_ORDER) begin
      order_n = ORD_W'(MAX_ORDER);
    end else begin
      order_n = ORD_W'(order_cfg);
    end
    order_nn = NN_W'(order_n) * NN_W'(order_n);
    in_range = NN_W'(element_index) < order_nn;
  end

  assign cmd       = cmd_t'(command);
  assign in_stall  = (state != S_IDLE) || (out_valid && out_stall);
  assign in_accept = in_valid && !in_stall;

  assign i_last = (ORD_W'(i_cnt) == order_n - ORD_W'(1));
  assign j_last = (ORD_W'(j_cnt) == order_n - ORD_W'(1));
  assign k_last = (ORD_W'(k_cnt) == order_n - ORD_W'(1));

  // Step issued this cycle
  always_comb begin
    ctrl0.valid = (state == S_MAC);
    ctrl0.first = (k_cnt == '0);
    ctrl0.last  = k_last;
    ctrl0.fin   = k_last && j_last && i_last;
    caddr0      = row_base + IDX_W'(j_cnt);
  end

  // Order register
  always_ff @(posedge clk) begin
    if (rst) begin
      order_cfg <= ORDER_RESET;
    end else if (cfg_write_en) begin
      order_cfg <= cfg_write_data;
    end
  end

  mme_operand_ram #(.DEPTH(DEPTH), .AW(IDX_W), .WW(WORD_WIDTH)) u_a_ram (
    .clk   (clk),
    .we    (in_accept && cmd == CMD_WRITE_A && in_range),
    .waddr (element_index),
    .wdata (element_value),
    .raddr (a_addr),
    .rdata (a_rdata)
  );

  mme_operand_ram #(.DEPTH(DEPTH), .AW(IDX_W), .WW(WORD_WIDTH)) u_b_ram (
    .clk   (clk),
    .we    (in_accept && cmd == CMD_WRITE_B && in_range),
    .waddr (element_index),
    .wdata (element_value),
    .raddr (b_addr),
    .rdata (b_rdata)
  );

  // Align step control with the registered operand reads
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1 <= '0;
    end else begin
      ctrl1 <= ctrl0;
    end
    caddr1 <= caddr0;
  end

  mme_mac #(.AW(IDX_W), .WW(WORD_WIDTH)) u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctrl_in  (ctrl1),
    .addr_in  (caddr1),
    .a        (a_rdata),
    .b        (b_rdata),
    .res_ctrl (res_ctrl),
    .res_addr (res_addr),
    .res_data (res_data)
  );

  // Store finished dot products into C
  always_ff @(posedge clk) begin
    if (res_ctrl.valid && res_ctrl.last) begin
      c_mem[res_addr] <= res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= '0;
    end else if (res_ctrl.valid && res_ctrl.last) begin
      c_valid[res_addr] <= 1'b1;
    end
  end

  // Sequencer: walk i, j, k and keep the operand addresses running
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept && cmd == CMD_START && order_n != '0) begin
            state <= S_MAC;
          end
        end
        S_MAC: begin
          if (k_last && j_last && i_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (res_ctrl.valid && res_ctrl.fin) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state != S_MAC) begin
      i_cnt    <= '0;
      j_cnt    <= '0;
      k_cnt    <= '0;
      row_base <= '0;
      a_addr   <= '0;
      b_addr   <= '0;
    end else if (!k_last) begin
      k_cnt  <= k_cnt + CNT_W'(1);
      a_addr <= a_addr + IDX_W'(1);
      b_addr <= b_addr + IDX_W'(order_n);
    end else begin
      k_cnt <= '0;
      if (!j_last) begin
        j_cnt  <= j_cnt + CNT_W'(1);
        a_addr <= row_base;
        b_addr <= IDX_W'(j_cnt) + IDX_W'(1);
      end else begin
        j_cnt    <= '0;
        i_cnt    <= i_cnt + CNT_W'(1);
        row_base <= row_base + IDX_W'(order_n);
        a_addr   <= row_base + IDX_W'(order_n);
        b_addr   <= '0;
      end
    end
  end

  // Done flag and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_accept) begin
        case (cmd)
          CMD_WRITE_A, CMD_WRITE_B: begin
            out_valid <= 1'b1;
            if (in_range) begin
              done_flag <= 1'b0;
              done_res  <= 1'b0;
            end else begin
              done_res  <= done_flag;
            end
            read_data <= '0;
          end
          CMD_START: begin
            // Order zero finishes at once; otherwise wait for the drain
            if (order_n == '0) begin
              out_valid <= 1'b1;
              done_flag <= 1'b1;
              done_res  <= 1'b1;
              read_data <= '0;
            end
          end
          CMD_READ_C: begin
            out_valid <= 1'b1;
            done_res  <= done_flag;
            if (in_range && c_valid[element_index]) begin
              read_data <= c_mem[element_index];
            end else begin
              read_data <= '0;
            end
          end
          default: begin
            out_valid <= 1'b0;
          end
        endcase
      end else if (state == S_DRAIN && res_ctrl.valid && res_ctrl.fin) begin
        out_valid <= 1'b1;
        done_flag <= 1'b1;
        done_res  <= 1'b1;
        read_data <= '0;
      end
    end
  end

endmodule

// ----- sv/mme_operand_ram.sv -----
module mme_operand_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int WW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [WW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [WW-1:0] rdata
);

  logic [WW-1:0] mem [DEPTH];

  // Write one entry, read one entry into a register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/mme_mac.sv -----
module mme_mac #(
  parameter int AW = 4,
  parameter int WW = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  mme_pkg::mac_ctrl_t  ctrl_in,
  input  logic [AW-1:0]       addr_in,
  input  logic [WW-1:0]       a,
  input  logic [WW-1:0]       b,
  output mme_pkg::mac_ctrl_t  res_ctrl,
  output logic [AW-1:0]       res_addr,
  output logic [WW-1:0]       res_data
);
  import mme_pkg::*;

  mac_ctrl_t     ctrl_p;
  logic [AW-1:0] addr_p;
  logic [WW-1:0] prod;
  mac_ctrl_t     ctrl_r;
  logic [AW-1:0] addr_r;
  logic [WW-1:0] acc;

  // Control flow through the product and accumulate stages
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_p <= '0;
      ctrl_r <= '0;
    end else begin
      ctrl_p <= ctrl_in;
      ctrl_r <= ctrl_p;
    end
  end

  // Multiply; only the low word of the product is kept (wrapping)
  always_ff @(posedge clk) begin
    addr_p <= addr_in;
    prod   <= a * b;
  end

  // Accumulate, restarting on the first term of each dot product
  always_ff @(posedge clk) begin
    addr_r <= addr_p;
    if (ctrl_p.valid) begin
      acc <= ctrl_p.first ? prod : acc + prod;
    end
  end

  assign res_ctrl = ctrl_r;
  assign res_addr = addr_r;
  assign res_data = acc;

endmodule

// ----- test/matrix_multiply_engine_core_tb.sv -----
`timescale 1ns / 1ps

module matrix_multiply_engine_core_tb;
  import mme_pkg::*;

  localparam int ORDER_MAX    = MAX_ORDER_DEF;
  localparam int DEPTH        = ORDER_MAX * ORDER_MAX;
  localparam int WORD_W       = WORD_WIDTH_DEF;
  localparam int IDX_W        = $clog2(DEPTH);
  localparam int RANDOM_ITEMS = 1250;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 80;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int NUM_PHASES   = 13;
  localparam logic [ORDER_W-1:0] PHASE_ORDERS [NUM_PHASES] =
    '{3'd4, 3'd2, 3'd1, 3'd3, 3'd7, 3'd0, 3'd4, 3'd5, 3'd2, 3'd3, 3'd6, 3'd1, 3'd4};

  typedef logic [WORD_W-1:0] word_t;

  typedef struct {
    word_t data;
    logic  done;
  } product_result_t;

  // Mirror of the operand and result stores; queues one result per item
  class product_scoreboard;
    word_t              a_mat [DEPTH];
    word_t              b_mat [DEPTH];
    word_t              c_mat [DEPTH];
    logic               done_flag;
    logic [ORDER_W-1:0] order_reg;
    product_result_t    awaited [$];
    int                 errors;
    int                 results;
    int                 multiplies;
    int                 reads;

    function new();
      foreach (c_mat[i]) begin
        a_mat[i] = '0;
        b_mat[i] = '0;
        c_mat[i] = '0;
      end
      done_flag  = 1'b0;
      order_reg  = ORDER_RESET;
      errors     = 0;
      results    = 0;
      multiplies = 0;
      reads      = 0;
    endfunction

    function void set_order(logic [ORDER_W-1:0] value);
      order_reg = value;
    endfunction

    function void note_item(cmd_t cmd, logic [IDX_W-1:0] idx, word_t value);
      int              n;
      bit              in_range;
      word_t           acc;
      product_result_t res;
      n        = (order_reg > ORDER_MAX) ? ORDER_MAX : int'(order_reg);
      in_range = int'(idx) < n * n;
      res.data = '0;
      case (cmd)
        CMD_WRITE_A: begin
          if (in_range) begin
            a_mat[idx] = value;
            done_flag  = 1'b0;
          end
        end
        CMD_WRITE_B: begin
          if (in_range) begin
            b_mat[idx] = value;
            done_flag  = 1'b0;
          end
        end
        CMD_START: begin
          // Wrapping dot products at the word width
          for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
              acc = '0;
              for (int k = 0; k < n; k++)
                acc = acc + a_mat[i * n + k] * b_mat[k * n + j];
              c_mat[i * n + j] = acc;
            end
          end
          done_flag = 1'b1;
          multiplies++;
        end
        default: begin
          if (in_range) res.data = c_mat[idx];
          reads++;
        end
      endcase
      res.done = done_flag;
      awaited.push_back(res);
    endfunction

    function void check_result(word_t data, logic done);
      product_result_t want;
      results++;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending: read_data %h done_res %b",
                 $time, data, done);
        return;
      end
      want = awaited.pop_front();
      if (data !== want.data) begin
        errors++;
        $display("%0t: read_data expected %h actual %h", $time, want.data, data);
      end
      if (done !== want.done) begin
        errors++;
        $display("%0t: done_res expected %b actual %b", $time, want.done, done);
      end
    endfunction
  endclass

  logic               clk            = 1'b0;
  logic               rst            = 1'b1;
  logic               cfg_write_en   = 1'b0;
  logic [ORDER_W-1:0] cfg_write_data = '0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic [1:0]         command        = '0;
  logic [IDX_W-1:0]   element_index  = '0;
  word_t              element_value  = '0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  word_t              read_data;
  logic               done_res;

  int             tx_idle_pct  = 0;
  int             rx_idle_pct  = 0;
  int             hold_reqs    = 0;
  int             cycle_count  = 0;
  int             items_sent   = 0;
  int             random_start = 0;
  int             cur_nn       = DEPTH;
  logic [DEPTH-1:0] a_written  = '0;
  logic [DEPTH-1:0] b_written  = '0;

  product_scoreboard sb = new();

  matrix_multiply_engine_core DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .element_index  (element_index),
    .element_value  (element_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_data      (read_data),
    .done_res       (done_res)
  );

  always #2 clk = ~clk;

  // Note config writes, accepted items and results in edge order
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write_en) sb.set_order(cfg_write_data);
      if (in_valid && !in_stall)
        sb.note_item(cmd_t'(command), element_index, element_value);
      if (out_valid && !out_stall) sb.check_result(read_data, done_res);
    end
  end

  // Stall results at random; hold off for a long stretch on request
  initial begin : receiver
    int holds_served;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_served) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[matrix_multiply_engine_core] ERROR");
      $finish;
    end
  end

  function automatic word_t random_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return word_t'($urandom_range(16)) - word_t'(8);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic bit operands_ready();
    for (int i = 0; i < cur_nn; i++)
      if (!a_written[i] || !b_written[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Offer one item after an optional gap and hold it until accepted
  task automatic drive_item(cmd_t cmd, int idx, word_t value);
    if (items_sent < random_start + RANDOM_ITEMS / 3) begin
      tx_idle_pct = 17;
      rx_idle_pct = 54;
    end else if (items_sent < random_start + 2 * RANDOM_ITEMS / 3) begin
      tx_idle_pct = 54;
      rx_idle_pct = 17;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    if (idx < cur_nn) begin
      if (cmd == CMD_WRITE_A) a_written[idx] = 1'b1;
      if (cmd == CMD_WRITE_B) b_written[idx] = 1'b1;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    element_index <= IDX_W'(idx);
    element_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait for every pending result
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_order(logic [ORDER_W-1:0] value);
    int n;
    wait_idle();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    n      = (value > ORDER_MAX) ? ORDER_MAX : int'(value);
    cur_nn = n * n;
  endtask

  // Load A and B, multiply, read back all of C plus one random index
  task automatic product_sequence();
    for (int i = 0; i < cur_nn; i++)
      if (!a_written[i] || $urandom_range(99) < 75)
        drive_item(CMD_WRITE_A, i, random_word());
    for (int i = 0; i < cur_nn; i++)
      if (!b_written[i] || $urandom_range(99) < 75)
        drive_item(CMD_WRITE_B, i, random_word());
    drive_item(CMD_START, $urandom_range(DEPTH - 1), random_word());
    for (int i = 0; i < cur_nn; i++)
      drive_item(CMD_READ_C, i, random_word());
    drive_item(CMD_READ_C, $urandom_range(DEPTH - 1), random_word());
  endtask

  // Any command at any index; a start is only issued on written operands
  task automatic noise_item();
    cmd_t cmd;
    cmd = cmd_t'($urandom_range(3));
    if (cmd == CMD_START && !operands_ready()) cmd = CMD_READ_C;
    drive_item(cmd, $urandom_range(DEPTH - 1), random_word());
  endtask

  task automatic run_phase(logic [ORDER_W-1:0] order, int budget, bit hold);
    int stop;
    write_order(order);
    if (hold) hold_reqs <= hold_reqs + 1;
    stop = items_sent + budget;
    while (items_sent < stop) begin
      if ($urandom_range(99) < 70) product_sequence();
      else repeat ($urandom_range(8, 1)) noise_item();
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reads before any multiply return zero with done low
    drive_item(CMD_READ_C, 0, '0);
    drive_item(CMD_READ_C, DEPTH - 1, '1);

    // Order one: extreme operands, out-of-range writes and reads
    write_order(3'd1);
    drive_item(CMD_WRITE_A, 0, 32'h7FFF_FFFF);
    drive_item(CMD_WRITE_B, 0, 32'h8000_0000);
    drive_item(CMD_WRITE_A, 9, 32'h1234_5678);
    drive_item(CMD_START, 0, '0);
    drive_item(CMD_READ_C, 0, '0);
    drive_item(CMD_READ_C, 1, '0);
    drive_item(CMD_WRITE_B, 1, '1);
    drive_item(CMD_READ_C, 0, '0);
    drive_item(CMD_WRITE_B, 0, '1);
    drive_item(CMD_READ_C, 0, '0);
    drive_item(CMD_START, DEPTH - 1, '1);
    drive_item(CMD_READ_C, 0, '0);

    // Order zero: nothing is in range, start still sets done
    write_order(3'd0);
    drive_item(CMD_START, 0, '0);
    drive_item(CMD_READ_C, 0, '0);
    drive_item(CMD_WRITE_A, 0, 32'h1);
    drive_item(CMD_WRITE_B, DEPTH - 1, 32'h8000_0000);
    drive_item(CMD_READ_C, DEPTH - 1, '0);

    // Order seven saturates; old C entries reread with the new packing
    write_order(3'd7);
    drive_item(CMD_READ_C, 0, '0);
    drive_item(CMD_READ_C, DEPTH - 1, '0);

    // Random phases across orders, with two long receiver hold-offs
    random_start = items_sent;
    for (int p = 0; p < NUM_PHASES; p++)
      run_phase(PHASE_ORDERS[p], RANDOM_ITEMS / NUM_PHASES, p == 1 || p == 10);

    wait_idle();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d items over orders 0 to 7 with idle, stall and hold-off phases",
             items_sent);
    $display("Checked %0d results: %0d multiplies, %0d reads of C, %0d mismatches",
             sb.results, sb.multiplies, sb.reads, sb.errors);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("[matrix_multiply_engine_core] OK");
    end else begin
      $display("[matrix_multiply_engine_core] ERROR");
    end
    $finish;
  end

endmodule
